// File: src/flac_metadata_stream_parser_core_assert.svh
// assertion macros used by the checker file
// clk and rst_n are taken from the scope of the use
`ifndef FLAC_METADATA_STREAM_PARSER_CORE_ASSERT_SVH
`define FLAC_METADATA_STREAM_PARSER_CORE_ASSERT_SVH

// property checked outside reset
`define FMSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define FMSP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/flac_mdp_pkg.sv
package flac_mdp_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_HEADER,
    PH_PAYLOAD,
    PH_AUDIO,
    PH_ERROR
  } phase_t;

  // position inside a vorbis comment block
  typedef enum logic [2:0] {
    CP_VENDOR_LEN,
    CP_VENDOR_STR,
    CP_COUNT,
    CP_COMMENT_LEN,
    CP_COMMENT_STR
  } cmt_phase_t;

  // byte classes
  typedef enum logic [3:0] {
    CLS_MAGIC,
    CLS_HEADER,
    CLS_PAYLOAD,
    CLS_FRAMING,
    CLS_KEY,
    CLS_SEPARATOR,
    CLS_VALUE,
    CLS_PICTURE,
    CLS_AUDIO,
    CLS_ERROR
  } byte_cls_t;

  localparam logic [6:0] TYPE_VORBIS  = 7'd4;
  localparam logic [6:0] TYPE_PICTURE = 7'd6;
  localparam logic [6:0] TYPE_MASK    = 7'b1111111;
  localparam logic [7:0] SEPARATOR    = 8'h3D;
  localparam logic [7:0] UPPER_A      = 8'h41;
  localparam logic [7:0] UPPER_Z      = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // one input byte
  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } item_t;

  // one result
  typedef struct packed {
    logic       end_of_unit;
    logic       last_block;
    logic [6:0] block_type;
    logic [7:0] out_byte;
    byte_cls_t  byte_class;
  } result_t;

  // expected magic byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = 8'h66;
      2'd1: m = 8'h4C;
      2'd2: m = 8'h61;
      2'd3: m = 8'h43;
      default: m = 8'h66;
    endcase
    return m;
  endfunction

endpackage

// File: src/flac_mdp_in_stage.sv
module flac_mdp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid_i,
  input  flac_mdp_pkg::item_t  in_item_i,
  input  logic                 take_i,
  output logic                 in_ready_o,
  output logic                 valid_o,
  output flac_mdp_pkg::item_t  item_o
);
  import flac_mdp_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_r || take_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid_i && in_ready_o) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  // control bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid_i && in_ready_o) begin
      item_r <= in_item_i;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

// File: src/flac_mdp_classify.sv
module flac_mdp_classify (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_i,
  input  flac_mdp_pkg::item_t    item_i,
  output flac_mdp_pkg::result_t  result_o
);
  import flac_mdp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [23:0] block_left_r, block_left_nxt;
  logic [6:0]  cur_type_r, cur_type_nxt;
  logic        last_flag_r, last_flag_nxt;
  cmt_phase_t  cphase_r, cphase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] str_left_r, str_left_nxt;
  logic        seen_sep_r, seen_sep_nxt;

  // state seen by this byte (restart clears it first)
  phase_t      ph;
  logic [1:0]  idx;
  logic [23:0] blk;
  logic [6:0]  ctype;
  logic        lflag;
  cmt_phase_t  cph;
  logic [31:0] acc;
  logic [31:0] sleft;
  logic        ssep;

  logic [7:0]  b;
  logic [31:0] acc_or;
  logic [31:0] sleft_dec;
  logic [23:0] blk_dec;
  byte_cls_t   cls;
  logic [7:0]  ob;
  logic        eou;

  assign b         = item_i.data_byte;

  always_comb begin
    if (item_i.restart) begin
      ph    = PH_MAGIC;
      idx   = 2'd0;
      blk   = 24'd0;
      ctype = 7'd0;
      lflag = 1'b0;
      cph   = CP_VENDOR_LEN;
      acc   = 32'd0;
      sleft = 32'd0;
      ssep  = 1'b0;
    end else begin
      ph    = phase_r;
      idx   = idx_r;
      blk   = block_left_r;
      ctype = cur_type_r;
      lflag = last_flag_r;
      cph   = cphase_r;
      acc   = accum_r;
      sleft = str_left_r;
      ssep  = seen_sep_r;
    end
  end

  assign acc_or    = acc | ({24'd0, b} << {idx, 3'b000});
  assign sleft_dec = sleft - 32'd1;
  assign blk_dec   = blk - 24'd1;

  // next state and result for one byte
  always_comb begin
    phase_nxt      = ph;
    idx_nxt        = idx;
    block_left_nxt = blk;
    cur_type_nxt   = ctype;
    last_flag_nxt  = lflag;
    cphase_nxt     = cph;
    accum_nxt      = acc;
    str_left_nxt   = sleft;
    seen_sep_nxt   = ssep;
    cls            = CLS_ERROR;
    ob             = b;
    eou            = 1'b0;

    unique case (ph)
      PH_MAGIC: begin
        if (b == magic_byte(idx)) begin
          cls = CLS_MAGIC;
          if (idx == 2'd3) begin
            phase_nxt = PH_HEADER;
            idx_nxt   = 2'd0;
          end else begin
            idx_nxt = idx + 2'd1;
          end
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_HEADER: begin
        cls = CLS_HEADER;
        if (idx == 2'd0) begin
          last_flag_nxt  = b[7];
          cur_type_nxt   = b[6:0] & TYPE_MASK;
          block_left_nxt = 24'd0;
          idx_nxt        = 2'd1;
        end else begin
          block_left_nxt = {blk[15:0], b};
          if (idx == 2'd3) begin
            idx_nxt      = 2'd0;
            cphase_nxt   = CP_VENDOR_LEN;
            accum_nxt    = 32'd0;
            str_left_nxt = 32'd0;
            seen_sep_nxt = 1'b0;
            if ({blk[15:0], b} != 24'd0) begin
              phase_nxt = PH_PAYLOAD;
            end else if (lflag) begin
              phase_nxt = PH_AUDIO;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end else begin
            idx_nxt = idx + 2'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (ctype == TYPE_VORBIS) begin
          cls = CLS_FRAMING;
          // little-endian length fields
          if (cph == CP_VENDOR_LEN || cph == CP_COUNT || cph == CP_COMMENT_LEN) begin
            accum_nxt = acc_or;
            if (idx == 2'd3) begin
              idx_nxt   = 2'd0;
              accum_nxt = 32'd0;
              if (cph == CP_VENDOR_LEN) begin
                str_left_nxt = acc_or;
                cphase_nxt   = (acc_or != 32'd0) ? CP_VENDOR_STR : CP_COUNT;
              end else if (cph == CP_COUNT) begin
                cphase_nxt = CP_COMMENT_LEN;
              end else begin
                str_left_nxt = acc_or;
                seen_sep_nxt = 1'b0;
                if (acc_or != 32'd0) begin
                  cphase_nxt = CP_COMMENT_STR;
                end else begin
                  eou = 1'b1;
                end
              end
            end else begin
              idx_nxt = idx + 2'd1;
            end
          end else if (cph == CP_VENDOR_STR) begin
            str_left_nxt = sleft_dec;
            if (sleft_dec == 32'd0) begin
              cphase_nxt = CP_COUNT;
              idx_nxt    = 2'd0;
              accum_nxt  = 32'd0;
            end
          end else begin
            // comment string: key, first separator, value
            if (!ssep && b == SEPARATOR) begin
              cls          = CLS_SEPARATOR;
              seen_sep_nxt = 1'b1;
            end else if (!ssep) begin
              cls = CLS_KEY;
              if (b >= UPPER_A && b <= UPPER_Z) begin
                ob = b + CASE_OFFSET;
              end
            end else begin
              cls = CLS_VALUE;
            end
            str_left_nxt = sleft_dec;
            if (sleft_dec == 32'd0) begin
              eou        = 1'b1;
              cphase_nxt = CP_COMMENT_LEN;
              idx_nxt    = 2'd0;
              accum_nxt  = 32'd0;
            end
          end
        end else if (ctype == TYPE_PICTURE) begin
          cls = CLS_PICTURE;
        end else begin
          cls = CLS_PAYLOAD;
        end
        // block payload countdown
        block_left_nxt = blk_dec;
        if (blk_dec == 24'd0) begin
          eou       = 1'b1;
          idx_nxt   = 2'd0;
          phase_nxt = lflag ? PH_AUDIO : PH_HEADER;
        end
      end
      PH_AUDIO: begin
        cls = CLS_AUDIO;
      end
      default: begin
        cls = CLS_ERROR;
      end
    endcase
  end

  assign result_o.byte_class  = cls;
  assign result_o.out_byte    = ob;
  assign result_o.block_type  = cur_type_nxt;
  assign result_o.last_block  = last_flag_nxt;
  assign result_o.end_of_unit = eou;

  // state registers advance once per byte that moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      idx_r        <= 2'd0;
      block_left_r <= 24'd0;
      cur_type_r   <= 7'd0;
      last_flag_r  <= 1'b0;
      cphase_r     <= CP_VENDOR_LEN;
      accum_r      <= 32'd0;
      str_left_r   <= 32'd0;
      seen_sep_r   <= 1'b0;
    end else if (step_i) begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      block_left_r <= block_left_nxt;
      cur_type_r   <= cur_type_nxt;
      last_flag_r  <= last_flag_nxt;
      cphase_r     <= cphase_nxt;
      accum_r      <= accum_nxt;
      str_left_r   <= str_left_nxt;
      seen_sep_r   <= seen_sep_nxt;
    end
  end

endmodule

// File: src/flac_mdp_out_stage.sv
module flac_mdp_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  flac_mdp_pkg::result_t  result_i,
  input  logic                   out_ready_i,
  output logic                   space_o,
  output logic                   valid_o,
  output flac_mdp_pkg::result_t  result_o
);
  import flac_mdp_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // room for a new result when empty or when the held one leaves now
  assign space_o = !valid_r || out_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule

// File: src/flac_metadata_stream_parser_core.sv
// FLAC metadata byte classifier. Takes one file byte per transfer and returns one
// classified result per byte, in order, at a sustained rate of one byte per clock
// while neither channel stalls. A byte passes through the input register, then
// through the classifier logic into the output register, which also advances the
// parser state; out_tvalid rises when the byte is loaded into the output register.
// Setting in_tuser on a byte starts a new file at that byte.
// Both channels may stall freely.
module flac_metadata_stream_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [14:8] block_type, [15] last_block
  output logic [3:0]  out_tuser,  // [3:0] byte_class
  output logic        out_tlast   // end_of_unit
);
  import flac_mdp_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_space;
  logic    step;
  result_t step_result;
  result_t out_result;

  assign in_item.data_byte = in_tdata;
  assign in_item.restart   = in_tuser;

  // a byte moves on when the output register has room
  assign step = s1_valid && out_space;

  flac_mdp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_item_i  (in_item),
    .take_i     (step),
    .in_ready_o (in_tready),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  flac_mdp_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .item_i   (s1_item),
    .result_o (step_result)
  );

  flac_mdp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (step),
    .result_i    (step_result),
    .out_ready_i (out_tready),
    .space_o     (out_space),
    .valid_o     (out_tvalid),
    .result_o    (out_result)
  );

  assign out_tdata = {out_result.last_block, out_result.block_type, out_result.out_byte};
  assign out_tuser = out_result.byte_class;
  assign out_tlast = out_result.end_of_unit;

endmodule

// File: src/flac_mdp_checker.sv
`include "flac_metadata_stream_parser_core_assert.svh"

module flac_mdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);
  import flac_mdp_pkg::*;

  logic        stalled;
  logic [20:0] out_bits;
  logic        key_byte;
  logic        key_upper;
  logic        payload_byte;

  assign stalled   = out_tvalid && !out_tready;
  assign out_bits  = {out_tlast, out_tuser, out_tdata};
  assign key_byte  = (out_tuser == CLS_KEY);
  assign key_upper = (out_tdata[7:0] >= UPPER_A) && (out_tdata[7:0] <= UPPER_Z);

  // classes that belong to a block payload
  assign payload_byte = (out_tuser == CLS_PAYLOAD) || (out_tuser == CLS_FRAMING) ||
                        (out_tuser == CLS_KEY) || (out_tuser == CLS_SEPARATOR) ||
                        (out_tuser == CLS_VALUE) || (out_tuser == CLS_PICTURE);

  // no result survives a reset
  `FMSP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")

  // a stalled result holds
  `FMSP_ASSERT(a_stall_hold, stalled |=> out_tvalid && $stable(out_bits), "stalled result moved")

  // key bytes never carry an upper-case letter
  `FMSP_ASSERT(a_key_lower, out_tvalid && key_byte |-> !key_upper, "key byte not lowercased")

  // unit end only on payload bytes
  `FMSP_ASSERT(a_eou_payload, out_tvalid && out_tlast |-> payload_byte, "unit end outside a payload")

  // class code in range
  `FMSP_ASSERT(a_class_range, out_tvalid |-> out_tuser <= CLS_ERROR, "byte class out of range")

endmodule

bind flac_metadata_stream_parser_core flac_mdp_checker u_flac_mdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: verif/tb_flac_metadata_stream_parser_core.sv
module tb_flac_metadata_stream_parser_core;
  import flac_mdp_pkg::*;

  // expected byte classes for every accepted file byte
  class flac_byte_board;
    phase_t     ph;
    cmt_phase_t cph;
    logic [1:0]  idx;
    logic [23:0] blk_left;
    logic [6:0]  cur_type;
    logic        last_f;
    logic [31:0] len_acc;
    logic [31:0] str_left;
    logic        sep_seen;
    logic [7:0]  magic_seq [4];
    result_t     pending_results[$];
    int          errors;

    function new();
      magic_seq = '{8'h66, 8'h4C, 8'h61, 8'h43};
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = PH_MAGIC;
      cph = CP_VENDOR_LEN;
      idx = 2'd0;
      blk_left = 24'd0;
      cur_type = 7'd0;
      last_f = 1'b0;
      len_acc = 32'd0;
      str_left = 32'd0;
      sep_seen = 1'b0;
    endfunction

    // one payload byte of a vorbis comment block
    function byte_cls_t comment_class(input logic [7:0] b, inout logic [7:0] ob,
                                      inout logic eou);
      byte_cls_t cls;
      cls = CLS_FRAMING;
      if (cph == CP_VENDOR_LEN || cph == CP_COUNT || cph == CP_COMMENT_LEN) begin
        // little-endian length or count field
        len_acc = len_acc | ({24'd0, b} << (8 * idx));
        if (idx == 2'd3) begin
          idx = 2'd0;
          case (cph)
            CP_VENDOR_LEN: begin
              str_left = len_acc;
              cph = (len_acc != 0) ? CP_VENDOR_STR : CP_COUNT;
            end
            CP_COUNT: cph = CP_COMMENT_LEN;
            default: begin
              str_left = len_acc;
              sep_seen = 1'b0;
              if (len_acc != 0) cph = CP_COMMENT_STR;
              else eou = 1'b1;
            end
          endcase
          len_acc = 32'd0;
        end else begin
          idx = idx + 2'd1;
        end
      end else if (cph == CP_VENDOR_STR) begin
        str_left = str_left - 32'd1;
        if (str_left == 0) begin
          cph = CP_COUNT;
          idx = 2'd0;
          len_acc = 32'd0;
        end
      end else begin
        // comment string: key, first '=', value
        if (!sep_seen && b == SEPARATOR) begin
          cls = CLS_SEPARATOR;
          sep_seen = 1'b1;
        end else if (!sep_seen) begin
          cls = CLS_KEY;
          if (b >= 8'h41 && b <= 8'h5A) ob = b + 8'h20;
        end else begin
          cls = CLS_VALUE;
        end
        str_left = str_left - 32'd1;
        if (str_left == 0) begin
          eou = 1'b1;
          cph = CP_COMMENT_LEN;
          idx = 2'd0;
          len_acc = 32'd0;
        end
      end
      return cls;
    endfunction

    // accepted input transfer: advance the parser copy and queue its result
    function void note_byte(input logic [7:0] b, input logic restart);
      byte_cls_t cls;
      logic [7:0] ob;
      logic eou;
      result_t want;
      cls = CLS_ERROR;
      ob = b;
      eou = 1'b0;
      if (restart) clear();
      case (ph)
        PH_MAGIC: begin
          if (b == magic_seq[idx]) begin
            cls = CLS_MAGIC;
            if (idx == 2'd3) begin
              ph = PH_HEADER;
              idx = 2'd0;
            end else begin
              idx = idx + 2'd1;
            end
          end else begin
            ph = PH_ERROR;
          end
        end
        PH_HEADER: begin
          cls = CLS_HEADER;
          if (idx == 2'd0) begin
            last_f = b[7];
            cur_type = b[6:0];
            blk_left = 24'd0;
            idx = 2'd1;
          end else begin
            blk_left = {blk_left[15:0], b};
            if (idx == 2'd3) begin
              idx = 2'd0;
              cph = CP_VENDOR_LEN;
              len_acc = 32'd0;
              str_left = 32'd0;
              sep_seen = 1'b0;
              if (blk_left != 0) ph = PH_PAYLOAD;
              else ph = last_f ? PH_AUDIO : PH_HEADER;
            end else begin
              idx = idx + 2'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (cur_type == TYPE_VORBIS) cls = comment_class(b, ob, eou);
          else if (cur_type == TYPE_PICTURE) cls = CLS_PICTURE;
          else cls = CLS_PAYLOAD;
          blk_left = blk_left - 24'd1;
          if (blk_left == 0) begin
            eou = 1'b1;
            idx = 2'd0;
            ph = last_f ? PH_AUDIO : PH_HEADER;
          end
        end
        PH_AUDIO: cls = CLS_AUDIO;
        default: cls = CLS_ERROR;
      endcase
      want.byte_class = cls;
      want.out_byte = ob;
      want.block_type = cur_type;
      want.last_block = last_f;
      want.end_of_unit = eou;
      pending_results.push_back(want);
    endfunction

    function void report(input string field, input logic [15:0] want,
                         input logic [15:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // accepted output transfer against the oldest expectation
    function void check_result(input logic [15:0] d, input logic [3:0] u, input logic l);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got tdata=%h tuser=%h tlast=%b",
                 $time, d, u, l);
        return;
      end
      want = pending_results.pop_front();
      if (u !== want.byte_class) report("byte_class", 16'(want.byte_class), 16'(u));
      if (d[7:0] !== want.out_byte) report("out_byte", 16'(want.out_byte), 16'(d[7:0]));
      if (d[14:8] !== want.block_type)
        report("block_type", 16'(want.block_type), 16'(d[14:8]));
      if (d[15] !== want.last_block) report("last_block", 16'(want.last_block), 16'(d[15]));
      if (l !== want.end_of_unit) report("end_of_unit", 16'(want.end_of_unit), 16'(l));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  flac_byte_board board;
  logic [7:0] file_bytes[$];
  logic [7:0] payload_q[$];
  int         sent;
  bit         steady;

  flac_metadata_stream_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: ready bursts, short stalls and a few long ones
  initial begin
    int r;
    out_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // byte mix for comment strings: letters, '=', case boundaries, anything
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 60) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 70) return SEPARATOR;
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 8'h40;
        1: return 8'h5B;
        2: return 8'h60;
        default: return 8'h7B;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic void push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) payload_q.push_back(v[8*i +: 8]);
  endfunction

  // vorbis comment payload: vendor, count, comments
  function automatic void gen_vorbis();
    int vlen;
    int ncom;
    int clen;
    vlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    push_le32(vlen);
    repeat (vlen) payload_q.push_back(8'($urandom));
    ncom = $urandom_range(0, 4);
    push_le32(($urandom_range(0, 3) == 0) ? $urandom : ncom);
    for (int i = 0; i < ncom; i++) begin
      clen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 29) == 0) push_le32($urandom);
      else push_le32(clen);
      repeat (clen) payload_q.push_back(text_byte());
    end
  endfunction

  // one random file: magic, metadata blocks, audio; sometimes broken
  function automatic void gen_file();
    int nblk;
    int size;
    int r;
    int keep;
    logic lastb;
    logic [6:0] typ;
    logic huge;
    file_bytes.delete();
    if ($urandom_range(0, 24) == 0) begin
      repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom));
      return;
    end
    file_bytes = '{8'h66, 8'h4C, 8'h61, 8'h43};
    if ($urandom_range(0, 14) == 0) file_bytes[$urandom_range(0, 3)] = 8'($urandom);
    nblk = $urandom_range(1, 4);
    for (int k = 0; k < nblk; k++) begin
      lastb = (k == nblk - 1) || ($urandom_range(0, 29) == 0);
      huge = 1'b0;
      payload_q.delete();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        typ = TYPE_VORBIS;
        gen_vorbis();
      end else if (r < 60) begin
        typ = TYPE_PICTURE;
        repeat ($urandom_range(1, 10)) payload_q.push_back(8'($urandom));
      end else begin
        typ = 7'($urandom);
        repeat ($urandom_range(0, 10)) payload_q.push_back(8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 22) begin
        repeat ($urandom_range(1, 6)) payload_q.push_back(text_byte());
      end
      size = payload_q.size();
      if (r < 15) begin
        size = $urandom_range(0, size);
      end else if (r < 25) begin
        size = $urandom_range(0, 24'hFFFFFF);
        huge = (size > payload_q.size());
      end
      file_bytes.push_back({lastb, typ});
      file_bytes.push_back(size[23:16]);
      file_bytes.push_back(size[15:8]);
      file_bytes.push_back(size[7:0]);
      for (int i = 0; i < size && i < payload_q.size(); i++) file_bytes.push_back(payload_q[i]);
      if (huge) break;
      if (lastb) begin
        repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
        break;
      end
    end
    // cut the file short now and then; the next file restarts the parser
    if ($urandom_range(0, 11) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endfunction

  // one input transfer, with an optional idle gap before it
  task automatic send_item(input logic [7:0] d, input logic r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_byte(d, r);
    sent++;
  endtask

  task automatic send_file(input bit restart_first);
    foreach (file_bytes[i]) send_item(file_bytes[i], restart_first && i == 0);
  endtask

  // hold the sender until every outstanding result has been seen
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = 1'b0;
    sent = 0;
    steady = 1'b0;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: last vorbis block, empty vendor, "A=" comment, cut-off length, audio
    file_bytes = '{8'h66, 8'h4C, 8'h61, 8'h43,
                   8'h84, 8'h00, 8'h00, 8'h0F,
                   8'h00, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h00, 8'h00,
                   8'h02, 8'h00, 8'h00, 8'h00,
                   8'h41, SEPARATOR, 8'h07,
                   8'hFF};
    send_file(1'b0);
    // directed: restart into a bad magic, error stays sticky
    file_bytes = '{8'h00, 8'h66};
    send_file(1'b1);
    drain();

    // random files
    while (sent < 1900) begin
      steady = ($urandom_range(0, 3) == 0);
      gen_file();
      send_file(1'b1);
      if ($urandom_range(0, 19) == 0) drain();
    end
    in_tvalid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
